FILE: hdl/pys_pkg.sv
// ----------------------------------------------------------------------------
// pys_pkg
// Shared types and constants for the pythagorean sum pipeline.
// ----------------------------------------------------------------------------
package pys_pkg;

  // multiplier operand slice width per pipeline stage
  localparam int unsigned CHUNK_BITS = 16;

  // pipeline control handed to every arithmetic unit
  typedef struct packed {
    logic en;
    logic valid;
  } pys_ctl_t;

endpackage

FILE: hdl/pys_div.sv
// ----------------------------------------------------------------------------
// pys_div
// Pipelined restoring fractional divider, one quotient bit per stage.
// Returns floor(num * 2^QB / den) for num < 2*den, with a side payload.
// ----------------------------------------------------------------------------
module pys_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QB = 40,
  parameter int unsigned SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pys_pkg::pys_ctl_t  ctl_i,
  input  logic [DW-1:0]      num_i,
  input  logic [DW-1:0]      den_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [QB:0]        quo_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NS = QB + 1;
  localparam int unsigned QW = QB + 1;

  logic          vld_q  [NS];
  logic [DW-1:0] rem_q  [NS];
  logic [DW-1:0] den_q  [NS];
  logic [QB:0]   quo_q  [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          vld_d;
    logic [DW-1:0] rem_d;
    logic [DW-1:0] den_d;
    logic [QB:0]   quo_d;
    logic [SW-1:0] side_d;

    if (k == 0) begin : g_first
      always_comb begin
        vld_d  = ctl_i.valid;
        den_d  = den_i;
        side_d = side_i;
        if (num_i >= den_i) begin
          rem_d = num_i - den_i;
          quo_d = QW'(1);
        end else begin
          rem_d = num_i;
          quo_d = '0;
        end
      end
    end else begin : g_next
      logic [DW:0] shl;
      logic [DW:0] den_x;
      assign shl   = {rem_q[k-1], 1'b0};
      assign den_x = {1'b0, den_q[k-1]};
      always_comb begin
        vld_d  = vld_q[k-1];
        den_d  = den_q[k-1];
        side_d = side_q[k-1];
        if (shl >= den_x) begin
          rem_d = DW'(shl - den_x);
          quo_d = {quo_q[k-1][QB-1:0], 1'b1};
        end else begin
          rem_d = shl[DW-1:0];
          quo_d = {quo_q[k-1][QB-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_d;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_d;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

FILE: hdl/pys_mul.sv
// ----------------------------------------------------------------------------
// pys_mul
// Pipelined multiplier: one operand slice per stage, then round half up
// and drop SH fraction bits. Carries a side payload.
// ----------------------------------------------------------------------------
module pys_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 41,
  parameter int unsigned SH = 40,
  parameter int unsigned RW = 48,
  parameter int unsigned SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pys_pkg::pys_ctl_t  ctl_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [RW-1:0]      prod_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned CW   = pys_pkg::CHUNK_BITS;
  localparam int unsigned NC   = (BW + CW - 1) / CW;
  localparam int unsigned BPW  = NC * CW;
  localparam int unsigned ACCW = AW + BPW;

  logic [BPW-1:0] b_pad;
  assign b_pad = BPW'(b_i);

  logic            vld_q  [NC];
  logic [AW-1:0]   a_q    [NC];
  logic [BPW-1:0]  b_q    [NC];
  logic [ACCW-1:0] acc_q  [NC];
  logic [SW-1:0]   side_q [NC];

  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic            vld_d;
    logic [AW-1:0]   a_d;
    logic [BPW-1:0]  b_d;
    logic [ACCW-1:0] acc_in;
    logic [SW-1:0]   side_d;
    logic [AW+CW-1:0] part;
    logic [ACCW-1:0] acc_d;

    if (k == 0) begin : g_first
      assign vld_d  = ctl_i.valid;
      assign a_d    = a_i;
      assign b_d    = b_pad;
      assign acc_in = '0;
      assign side_d = side_i;
    end else begin : g_next
      assign vld_d  = vld_q[k-1];
      assign a_d    = a_q[k-1];
      assign b_d    = b_q[k-1];
      assign acc_in = acc_q[k-1];
      assign side_d = side_q[k-1];
    end

    assign part  = (AW+CW)'(a_d) * (AW+CW)'(b_d[k*CW +: CW]);
    assign acc_d = acc_in + (ACCW'(part) << (k * CW));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        a_q[k]    <= a_d;
        b_q[k]    <= b_d;
        acc_q[k]  <= acc_d;
        side_q[k] <= side_d;
      end
    end
  end

  logic [ACCW-1:0] rnd_sum;
  logic            res_vld_q;
  logic [RW-1:0]   res_q;
  logic [SW-1:0]   res_side_q;

  assign rnd_sum = acc_q[NC-1] + (ACCW'(1) << (SH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      res_vld_q <= vld_q[NC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      res_q      <= rnd_sum[SH +: RW];
      res_side_q <= side_q[NC-1];
    end
  end

  assign valid_o = res_vld_q;
  assign prod_o  = res_q;
  assign side_o  = res_side_q;

endmodule

FILE: hdl/pys_pass.sv
// ----------------------------------------------------------------------------
// pys_pass
// One cubic refinement pass: s = r/(4+r), u = 1+2s, p = p*u,
// q = s/u, r = q*q*r. Fully pipelined.
// ----------------------------------------------------------------------------
module pys_pass #(
  parameter int unsigned W  = 40,
  parameter int unsigned PW = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pys_pkg::pys_ctl_t  ctl_i,
  input  logic [PW-1:0]      p_i,
  input  logic [W:0]         r_i,
  output logic               valid_o,
  output logic [PW-1:0]      p_o,
  output logic [W:0]         r_o
);

  localparam int unsigned RW = W + 1;
  localparam int unsigned SW_S = PW + RW;
  localparam int unsigned SW_Q = PW + RW + RW;
  localparam int unsigned SW_P = RW + RW;

  // s = r / (4 + r)
  logic [W+2:0]    four_r;
  logic            s_vld;
  logic [W:0]      s_val;
  logic [SW_S-1:0] s_side;

  assign four_r = (W+3)'(r_i) + ((W+3)'(4) << W);

  pys_div #(.DW(W + 3), .QB(W), .SW(SW_S)) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_i),
    .num_i   ((W+3)'(r_i)),
    .den_i   (four_r),
    .side_i  ({p_i, r_i}),
    .valid_o (s_vld),
    .quo_o   (s_val),
    .side_o  (s_side)
  );

  // q = s / u, u = 1 + 2s
  logic [W:0]      u_val;
  logic            q_vld;
  logic [W:0]      q_val;
  logic [SW_Q-1:0] q_side;

  assign u_val = (RW'(1) << W) + {s_val[W-1:0], 1'b0};

  pys_div #(.DW(RW), .QB(W), .SW(SW_Q)) u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: ctl_i.en, valid: s_vld}),
    .num_i   (s_val),
    .den_i   (u_val),
    .side_i  ({s_side, u_val}),
    .valid_o (q_vld),
    .quo_o   (q_val),
    .side_o  (q_side)
  );

  // p = p * u
  logic            pu_vld;
  logic [PW-1:0]   pu_val;
  logic [SW_P-1:0] pu_side;

  pys_mul #(.AW(PW), .BW(RW), .SH(W), .RW(PW), .SW(SW_P)) u_mul_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: ctl_i.en, valid: q_vld}),
    .a_i     (q_side[SW_Q-1 -: PW]),
    .b_i     (q_side[RW-1:0]),
    .side_i  ({q_val, q_side[RW +: RW]}),
    .valid_o (pu_vld),
    .prod_o  (pu_val),
    .side_o  (pu_side)
  );

  // qq = q * q
  logic                qq_vld;
  logic [W:0]          qq_val;
  logic [PW+RW-1:0]    qq_side;

  pys_mul #(.AW(RW), .BW(RW), .SH(W), .RW(RW), .SW(PW + RW)) u_mul_qq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: ctl_i.en, valid: pu_vld}),
    .a_i     (pu_side[SW_P-1 -: RW]),
    .b_i     (pu_side[SW_P-1 -: RW]),
    .side_i  ({pu_val, pu_side[RW-1:0]}),
    .valid_o (qq_vld),
    .prod_o  (qq_val),
    .side_o  (qq_side)
  );

  // r = qq * r
  pys_mul #(.AW(RW), .BW(RW), .SH(W), .RW(RW), .SW(PW)) u_mul_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: ctl_i.en, valid: qq_vld}),
    .a_i     (qq_val),
    .b_i     (qq_side[RW-1:0]),
    .side_i  (qq_side[PW+RW-1 -: PW]),
    .valid_o (valid_o),
    .prod_o  (r_o),
    .side_o  (p_o)
  );

endmodule

FILE: hdl/pythagorean_sum.sv
// ----------------------------------------------------------------------------
// pythagorean_sum
// sqrt(x^2 + y^2) of two signed operands by the cubic ratio iteration,
// fully pipelined, one operand pair per cycle.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)            | tuser / tlast
//  s_axis   | in        | x_value, y_value              | none
//  m_axis   | out       | magnitude                     | none
//
//  One transaction per cycle in and out while m_axis accepts. Stages in order:
//  input register, ratio divider, squaring multiplier, ITERATIONS refinement
//  passes of pys_pass and the output register; W = WORK_BITS.
//  Reset clears all valid bits; no state survives between pairs.
//  A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
// ----------------------------------------------------------------------------
module pythagorean_sum #(
  parameter int unsigned IN_WIDTH   = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned WORK_BITS  = 40,
  parameter int unsigned ITERATIONS = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // x_value, y_value
  input  logic [((2*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // magnitude
  output logic [((IN_WIDTH+FRAC_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned W    = WORK_BITS;
  localparam int unsigned RW   = W + 1;
  localparam int unsigned PW   = IN_WIDTH + FRAC_BITS;
  localparam int unsigned OUTW = ((PW + 7) / 8) * 8;

  logic en;
  logic out_vld_q;
  logic [PW-1:0] mag_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // magnitudes and ordering
  logic [IN_WIDTH-1:0] x_raw, y_raw, ax, ay;
  logic                in_vld_q;
  logic [IN_WIDTH-1:0] big_q, small_q;

  assign x_raw = s_axis_tdata_i[IN_WIDTH-1:0];
  assign y_raw = s_axis_tdata_i[2*IN_WIDTH-1 -: IN_WIDTH];
  assign ax    = x_raw[IN_WIDTH-1] ? (~x_raw + IN_WIDTH'(1)) : x_raw;
  assign ay    = y_raw[IN_WIDTH-1] ? (~y_raw + IN_WIDTH'(1)) : y_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      big_q   <= (ax > ay) ? ax : ay;
      small_q <= (ax > ay) ? ay : ax;
    end
  end

  // ratio = small / big
  logic                ratio_vld;
  logic [W:0]          ratio;
  logic [IN_WIDTH-1:0] ratio_big;

  pys_div #(.DW(IN_WIDTH), .QB(W), .SW(IN_WIDTH)) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: in_vld_q}),
    .num_i   (small_q),
    .den_i   (big_q),
    .side_i  (big_q),
    .valid_o (ratio_vld),
    .quo_o   (ratio),
    .side_o  (ratio_big)
  );

  // r = ratio^2, p = big scaled
  logic          pv_w [ITERATIONS+1];
  logic [PW-1:0] p_w  [ITERATIONS+1];
  logic [W:0]    r_w  [ITERATIONS+1];

  pys_mul #(.AW(RW), .BW(RW), .SH(W), .RW(RW), .SW(PW)) u_mul_r0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: ratio_vld}),
    .a_i     (ratio),
    .b_i     (ratio),
    .side_i  (PW'(ratio_big) << FRAC_BITS),
    .valid_o (pv_w[0]),
    .prod_o  (r_w[0]),
    .side_o  (p_w[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_pass
    pys_pass #(.W(W), .PW(PW)) u_pass (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   ('{en: en, valid: pv_w[i]}),
      .p_i     (p_w[i]),
      .r_i     (r_w[i]),
      .valid_o (pv_w[i+1]),
      .p_o     (p_w[i+1]),
      .r_o     (r_w[i+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pv_w[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= p_w[ITERATIONS];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUTW'(mag_q);

endmodule
